FILE: rtl/utf8d_pkg.sv
// utf8d_pkg: widths, constants and types shared by the UTF-8 decoder
// and its port checker. No dependencies.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  // code point padded up to whole bytes on the master stream
  localparam int unsigned OUT_DATA_W = ((CP_W + 7) / 8) * 8;

  localparam logic [CP_W-1:0] REPLACEMENT_RESET = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CODE_POINT    = 21'h10FFFF;
  localparam logic [CP_W-1:0] MIN_TWO_BYTE      = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THREE_BYTE    = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR_BYTE     = 21'h010000;

  localparam logic [BYTE_W-1:0] ASCII_MAX      = 8'h7F;
  localparam logic [BYTE_W-1:0] LEAD2_MAX      = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MAX      = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_VALID_MAX = 8'hF7;

  // total sequence length minus one
  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } seq_len_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/utf8_code_point_decoder_unit.sv
// utf8_code_point_decoder_unit: byte-stream UTF-8 decoder, top level.
// Depends on utf8d_pkg.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | s_tdata = data_byte, s_tlast = end_of_stream
//  m_*     | out | m_tvalid / m_tready  | m_tdata = code_point (+3 zero bits),
//          |     |                      | m_tuser = replaced
//  cfg_*   | in  | cfg_valid / cfg_ready| cfg_data = replacement_value
//
// One byte per cycle while the skid entry is empty. With the output register free,
// a result appears on m_* the cycle after the byte that completes (or breaks) a
// sequence is taken. The decode state updates in the accept cycle; the result goes
// to an output register backed by one skid entry, so a stalled sink holds up input
// only once both are full.
// rst (synchronous, active high) clears the sequence state and both output
// entries and loads replacement_value with U+FFFD. cfg_ready is always high.
`default_nettype none

module utf8_code_point_decoder_unit
  import utf8d_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // slave stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
  input  wire logic                  s_tlast,   // end_of_stream
  // master stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [20:0] code_point, [23:21] zero
  output logic                       m_tuser,   // [0] replaced
  // configuration write
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CP_W-1:0]       cfg_data   // [20:0] replacement_value
);

  // ---------------------------------------------------------------- state
  logic [CP_W-1:0] replacement_value;
  logic [1:0]      bytes_remaining;
  seq_len_t        sequence_length;
  logic [CP_W-1:0] partial_value;
  logic            lead_invalid;

  logic [1:0]      bytes_remaining_next;
  seq_len_t        sequence_length_next;
  logic [CP_W-1:0] partial_value_next;
  logic            lead_invalid_next;

  logic            res_valid;
  result_t         res;

  // output register and skid entry
  logic            out_valid;
  result_t         out_res;
  logic            skid_valid;
  result_t         skid_res;

  logic            accept;
  logic            emit;
  logic            out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign emit      = accept && res_valid;
  assign out_free  = !out_valid || m_tready;

  // ---------------------------------------------------------------- decode
  logic [CP_W-1:0] shifted;
  logic [1:0]      rem_dec;
  logic            bad;

  always_comb begin
    shifted = {partial_value[CP_W-7:0], s_tdata[5:0]};
    rem_dec = bytes_remaining - 2'd1;

    // overlong / range check on a completed sequence
    unique case (sequence_length)
      SEQ_TWO:   bad = shifted < MIN_TWO_BYTE;
      SEQ_THREE: bad = shifted < MIN_THREE_BYTE;
      SEQ_FOUR:  bad = (shifted < MIN_FOUR_BYTE) || (shifted > MAX_CODE_POINT);
      default:   bad = 1'b1;
    endcase
    if (lead_invalid) begin
      bad = 1'b1;
    end

    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    partial_value_next   = partial_value;
    lead_invalid_next    = lead_invalid;
    res_valid            = 1'b0;
    res.code_point       = replacement_value;
    res.replaced         = 1'b1;

    if (bytes_remaining == 2'd0) begin
      if (s_tdata <= ASCII_MAX) begin
        res_valid      = 1'b1;
        res.code_point = {{(CP_W-BYTE_W){1'b0}}, s_tdata};
        res.replaced   = 1'b0;
      end else begin
        // lead byte: stray continuations count as two-byte leads
        if (s_tdata <= LEAD2_MAX) begin
          sequence_length_next = SEQ_TWO;
          partial_value_next   = {{(CP_W-5){1'b0}}, s_tdata[4:0]};
        end else if (s_tdata <= LEAD3_MAX) begin
          sequence_length_next = SEQ_THREE;
          partial_value_next   = {{(CP_W-4){1'b0}}, s_tdata[3:0]};
        end else begin
          sequence_length_next = SEQ_FOUR;
          partial_value_next   = {{(CP_W-3){1'b0}}, s_tdata[2:0]};
        end
        lead_invalid_next    = s_tdata > LEAD4_VALID_MAX;
        bytes_remaining_next = sequence_length_next;
        if (s_tlast) begin
          res_valid = 1'b1;   // cut short at end of stream
        end
      end
    end else begin
      partial_value_next   = shifted;
      bytes_remaining_next = rem_dec;
      if (rem_dec == 2'd0) begin
        res_valid = 1'b1;
        if (!bad) begin
          res.code_point = shifted;
          res.replaced   = 1'b0;
        end
      end else if (s_tlast) begin
        res_valid = 1'b1;
      end
    end

    // any emitted result ends the sequence
    if (res_valid) begin
      bytes_remaining_next = 2'd0;
      sequence_length_next = SEQ_NONE;
      partial_value_next   = '0;
      lead_invalid_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_value <= REPLACEMENT_RESET;
      bytes_remaining   <= 2'd0;
      sequence_length   <= SEQ_NONE;
      partial_value     <= '0;
      lead_invalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        replacement_value <= cfg_data;
      end
      if (accept) begin
        bytes_remaining <= bytes_remaining_next;
        sequence_length <= sequence_length_next;
        partial_value   <= partial_value_next;
        lead_invalid    <= lead_invalid_next;
      end
    end
  end

  // ---------------------------------------------------------------- output
  // skid holds a result only while the output register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!out_free && emit) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-CP_W){1'b0}}, out_res.code_point};
  assign m_tuser  = out_res.replaced;

endmodule

`default_nettype wire

FILE: rtl/utf8d_checker.sv
// utf8d_checker: port-level checks on the UTF-8 decoder, bound to the top.
// Depends on utf8d_pkg and utf8_code_point_decoder_unit.
`default_nettype none

module utf8d_checker
  import utf8d_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tuser
);

  // nothing left over after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output not empty after reset");

  // a decoded value that is not flagged is always within the code point range, up to U+10FFFF
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[CP_W-1:0] <= MAX_CODE_POINT)
    else $error("unflagged code point above U+10FFFF");

  // byte padding above the code point stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:CP_W] == '0)
    else $error("nonzero padding in m_tdata");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind utf8_code_point_decoder_unit utf8d_checker u_utf8d_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: test/testbench.sv
// testbench: self-checking bench for utf8_code_point_decoder_unit.
// Directed byte table, then random sequences under three idle profiles;
// depends on utf8d_pkg and the decoder RTL only.
module testbench;
  import utf8d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned SEG_BYTES = 80;

  // ---------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;      // [7:0] data_byte
  logic                  s_tlast = 1'b0;    // end_of_stream
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;           // [20:0] code_point, [23:21] zero
  logic                  m_tuser;           // [0] replaced
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CP_W-1:0]       cfg_data = '0;     // [20:0] replacement_value

  utf8_code_point_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Decoder state as the bench sees it, mirrors the block after reset
  // ---------------------------------------------------------------------
  logic [1:0]      pend_left  = 2'd0;        // continuation bytes still due
  seq_len_t        seq_kind   = SEQ_NONE;    // pending length minus one
  logic [CP_W-1:0] acc_value  = '0;          // value bits gathered so far
  logic            lead_bad   = 1'b0;        // lead was 0xF8..0xFF
  logic [CP_W-1:0] repl_value = REPLACEMENT_RESET;

  result_t cp_expected [$];                  // code points still to come out
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned src_gap_pct = 22;             // sender idle, percent of cycles
  int unsigned sink_stall_pct = 76;          // receiver stall, percent of cycles

  function automatic void clear_seq();
    pend_left = 2'd0;
    seq_kind  = SEQ_NONE;
    acc_value = '0;
    lead_bad  = 1'b0;
  endfunction

  // Advance the decoder by one byte; returns 1 when a code point comes out.
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic eos,
                                     output result_t res);
    bit bad;
    res = '0;
    if (pend_left == 2'd0) begin
      if (b <= ASCII_MAX) begin
        clear_seq();
        res.code_point = CP_W'(b);
        return 1'b1;
      end
      // stray continuation bytes fall into the two-byte class
      if (b <= LEAD2_MAX) begin
        seq_kind  = SEQ_TWO;
        acc_value = CP_W'(b[4:0]);
      end else if (b <= LEAD3_MAX) begin
        seq_kind  = SEQ_THREE;
        acc_value = CP_W'(b[3:0]);
      end else begin
        seq_kind  = SEQ_FOUR;
        acc_value = CP_W'(b[2:0]);
      end
      lead_bad  = (b > LEAD4_VALID_MAX);
      pend_left = seq_kind;
      if (eos) begin
        clear_seq();
        res = '{code_point: repl_value, replaced: 1'b1};
        return 1'b1;
      end
      return 1'b0;
    end
    // continuation: low six bits, top bits simply fall off the 21-bit value
    acc_value = {acc_value[CP_W-7:0], b[5:0]};
    pend_left = pend_left - 2'd1;
    if (pend_left == 2'd0) begin
      if (lead_bad)
        bad = 1'b1;
      else if (seq_kind == SEQ_TWO)
        bad = acc_value < MIN_TWO_BYTE;
      else if (seq_kind == SEQ_THREE)
        bad = acc_value < MIN_THREE_BYTE;
      else
        bad = (acc_value < MIN_FOUR_BYTE) || (acc_value > MAX_CODE_POINT);
      // surrogates are not checked and go out as decoded
      if (bad)
        res = '{code_point: repl_value, replaced: 1'b1};
      else
        res = '{code_point: acc_value, replaced: 1'b0};
      clear_seq();
      return 1'b1;
    end
    if (eos) begin
      // cut short by end of stream
      clear_seq();
      res = '{code_point: repl_value, replaced: 1'b1};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: random gaps (valid low) before each item, else valid held high across items
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eos,
                           input logic typed, input result_t typed_res);
    result_t pred;
    bit      has;
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    // item taken at this edge
    has = decode_byte(b, eos, pred);
    if (typed)
      cp_expected.push_back(typed_res);
    else if (has)
      cp_expected.push_back(pred);
    bytes_sent++;
  endtask

  // Mostly well-formed sequences with random payload, some truncated, some noise.
  task automatic send_random_seq();
    int unsigned     kind;
    int unsigned     n;
    int unsigned     i;
    logic [BYTE_W-1:0] lead;
    bit              cut;
    bit              eos_here;
    kind     = $urandom_range(99);
    eos_here = ($urandom_range(9) == 0);
    if (kind < 15) begin
      // raw noise: stray continuations, bad leads, anything
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++)
        push_byte(BYTE_W'($urandom_range(255)), eos_here && (i == n - 1), 1'b0, '0);
    end else begin
      if (kind < 35) begin
        n = 1;
        lead = BYTE_W'($urandom_range(8'h00, 8'h7F));
      end else if (kind < 60) begin
        n = 2;
        lead = BYTE_W'($urandom_range(8'hC0, 8'hDF));
      end else if (kind < 80) begin
        n = 3;
        lead = BYTE_W'($urandom_range(8'hE0, 8'hEF));
      end else begin
        n = 4;
        // bias toward F0..F4 so the 0x10FFFF boundary gets hit
        lead = ($urandom_range(3) == 0) ? BYTE_W'($urandom_range(8'hF0, 8'hFF))
                                        : BYTE_W'($urandom_range(8'hF0, 8'hF4));
      end
      cut = (n > 1) && ($urandom_range(9) == 0);
      if (cut) begin
        n = $urandom_range(1, n - 1);
        eos_here = 1'b1;
      end
      push_byte(lead, eos_here && (n == 1), 1'b0, '0);
      for (i = 1; i < n; i++)
        push_byte(8'h80 | BYTE_W'($urandom_range(63)), eos_here && (i == n - 1),
                  1'b0, '0);
    end
  endtask

  // Replacement write, only once the block has drained.
  task automatic set_replacement(input logic [CP_W-1:0] v);
    while (cp_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repl_value = v;
  endtask

  // ---------------------------------------------------------------------
  // Receiver stalls and result checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (cp_expected.size() == 0) begin
        $display("%0t: expected no item, got code_point=%h replaced=%b", $time,
                 m_tdata[CP_W-1:0], m_tuser);
        mismatch_count++;
      end else begin
        want = cp_expected.pop_front();
        if (m_tdata[CP_W-1:0] !== want.code_point || m_tuser !== want.replaced ||
            m_tdata[OUT_DATA_W-1:CP_W] !== '0) begin
          $display("%0t: expected code_point=%h replaced=%b, got tdata=%h replaced=%b",
                   $time, want.code_point, want.replaced, m_tdata, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed table: typed expectations only where obvious
  // ---------------------------------------------------------------------
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              eos;
    logic              typed;
    result_t           want;
  } dir_row_t;

  localparam result_t NO_RES   = '0;
  localparam result_t REPL_RES = '{code_point: REPLACEMENT_RESET, replaced: 1'b1};

  dir_row_t dir_rows [24] = '{
    '{8'h00, 1'b0, 1'b1, '{code_point: 21'h0, replaced: 1'b0}},
    '{8'h7F, 1'b0, 1'b1, '{code_point: 21'h7F, replaced: 1'b0}},
    // overlong two-byte form
    '{8'hC1, 1'b0, 1'b0, NO_RES},
    '{8'hBF, 1'b0, 1'b1, REPL_RES},
    // surrogate U+D800 passes through
    '{8'hED, 1'b0, 1'b0, NO_RES},
    '{8'hA0, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, NO_RES},
    // 0x110000, one past the top
    '{8'hF4, 1'b0, 1'b0, NO_RES},
    '{8'h90, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b1, REPL_RES},
    // 0x10FFFF, the top
    '{8'hF4, 1'b0, 1'b0, NO_RES},
    '{8'h8F, 1'b0, 1'b0, NO_RES},
    '{8'hBF, 1'b0, 1'b0, NO_RES},
    '{8'hBF, 1'b0, 1'b1, '{code_point: MAX_CODE_POINT, replaced: 1'b0}},
    // invalid lead eats four bytes
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, NO_RES},
    '{8'hBF, 1'b0, 1'b1, REPL_RES},
    // truncated three-byte sequence
    '{8'hE2, 1'b0, 1'b0, NO_RES},
    '{8'h82, 1'b1, 1'b1, REPL_RES},
    // end of stream on a lead byte
    '{8'hF0, 1'b1, 1'b1, REPL_RES},
    // stray continuation as two-byte lead, completed by the last byte
    '{8'hBF, 1'b0, 1'b0, NO_RES},
    '{8'hBF, 1'b1, 1'b0, NO_RES}
  };

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [CP_W-1:0] seg_repl [6];
    int unsigned     seg_start;
    seg_repl = '{21'h000000, MAX_CODE_POINT, 21'h1FFFFF,
                 CP_W'($urandom_range(21'h1FFFFF)), REPLACEMENT_RESET,
                 CP_W'($urandom_range(MAX_CODE_POINT))};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      push_byte(dir_rows[i].data, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].want);
    s_tvalid <= 1'b0;

    // six segments: two per idle profile, new replacement value each time
    for (int seg = 0; seg < 6; seg++) begin
      set_replacement(seg_repl[seg]);
      src_gap_pct    = (seg < 2) ? 22 : (seg < 4) ? 76 : 0;
      sink_stall_pct = (seg < 2) ? 76 : (seg < 4) ? 22 : 0;
      seg_start = bytes_sent;
      while (bytes_sent - seg_start < SEG_BYTES)
        send_random_seq();
      // a flagged last byte always leaves the decoder idle
      push_byte(BYTE_W'($urandom_range(255)), 1'b1, 1'b0, '0);
      s_tvalid <= 1'b0;
    end

    while (cp_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
